// ===== design/sfs_pkg.sv =====
// Shared types, widths and the reciprocal table for the flux smoother.
`timescale 1ns / 1ps
`default_nettype none
package sfs_pkg;

	localparam int PIX_W   = 8;
	localparam int NBR_N   = 8;               // spatial neighbours
	localparam int CAND_N  = NBR_N + 2;       // plus previous and next frame
	localparam int CNT_W   = 4;               // count is 1..11
	localparam int SUM_W   = 12;              // 11 * 255 fits
	localparam int FACT_W  = SUM_W + 1;       // 2*sum + count
	localparam int RECIP_W = 15;
	localparam int PROD_W  = FACT_W + RECIP_W;
	localparam int SHIFT   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 8;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
	localparam logic [PIX_W-1:0] THR_RESET = 8'd7;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMPORAL_THR = 2'd0,
		REG_SPATIAL_THR  = 2'd1,
		REG_SPATIAL_EN   = 2'd2
	} cfg_reg_t;

	// round(32768 / count), entry one held at 32767
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		case (cnt)
			4'd1:    r = 15'd32767;
			4'd2:    r = 15'd16384;
			4'd3:    r = 15'd10923;
			4'd4:    r = 15'd8192;
			4'd5:    r = 15'd6554;
			4'd6:    r = 15'd5461;
			4'd7:    r = 15'd4681;
			4'd8:    r = 15'd4096;
			4'd9:    r = 15'd3641;
			4'd10:   r = 15'd3277;
			4'd11:   r = 15'd2979;
			4'd12:   r = 15'd2731;
			4'd13:   r = 15'd2521;
			4'd14:   r = 15'd2341;
			4'd15:   r = 15'd2185;
			default: r = 15'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/spatiotemporal_flux_smoother.sv =====
// Temporal-extremum sigma smoother over a 3x3 neighbourhood, four-stage pipeline.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | request   | in_valid / in_stall  | center, prev/next frame, 8 nbrs, border
//  out     | result    | out_valid / out_stall| pixel_out
//  cfg     | write     | cfg_we               | cfg_index, cfg_data
//
// One pixel per clock unless out_stall holds the pipeline; out_valid is the valid bit of stage four.
// Stages: threshold compares, adder tree, 13x15 multiply, saturate.
// Each stage advances on its own, so bubbles close up under out_stall and
// in_stall rises only when all four stages hold a request.
// arst_n clears valid bits and restores register defaults (7, 7, on).
`timescale 1ns / 1ps
`default_nettype none
module spatiotemporal_flux_smoother
	import sfs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [PIX_W-1:0]     center_pixel,
	input  wire logic [PIX_W-1:0]     prev_frame_pixel,
	input  wire logic [PIX_W-1:0]     next_frame_pixel,
	input  wire logic [PIX_W-1:0]     up_left,
	input  wire logic [PIX_W-1:0]     up_mid,
	input  wire logic [PIX_W-1:0]     up_right,
	input  wire logic [PIX_W-1:0]     mid_left,
	input  wire logic [PIX_W-1:0]     mid_right,
	input  wire logic [PIX_W-1:0]     down_left,
	input  wire logic [PIX_W-1:0]     down_mid,
	input  wire logic [PIX_W-1:0]     down_right,
	input  wire logic                 is_border,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [PIX_W-1:0]          pixel_out,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// configuration
	pix_t temporal_thr_q;
	pix_t spatial_thr_q;
	logic spatial_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temporal_thr_q <= THR_RESET;
			spatial_thr_q  <= THR_RESET;
			spatial_en_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TEMPORAL_THR: temporal_thr_q <= cfg_data;
				REG_SPATIAL_THR:  spatial_thr_q  <= cfg_data;
				REG_SPATIAL_EN:   spatial_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage readiness, back to front
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !valid_s4 || !out_stall;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: extremum test and per-candidate threshold compare
	pix_t              cand   [CAND_N];
	pix_t              thr    [CAND_N];
	logic [CAND_N-1:0] acc;
	pix_t              masked [CAND_N];
	logic              extremum;

	always_comb begin
		logic [PIX_W:0] diff;
		cand[0] = prev_frame_pixel;
		cand[1] = next_frame_pixel;
		cand[2] = up_left;
		cand[3] = up_mid;
		cand[4] = up_right;
		cand[5] = mid_left;
		cand[6] = mid_right;
		cand[7] = down_left;
		cand[8] = down_mid;
		cand[9] = down_right;
		diff = '0;
		for (int k = 0; k < CAND_N; k++) begin
			thr[k] = (k < 2) ? temporal_thr_q : spatial_thr_q;
			diff = (cand[k] > center_pixel) ? {1'b0, cand[k]} - {1'b0, center_pixel}
			                                : {1'b0, center_pixel} - {1'b0, cand[k]};
			acc[k] = (diff <= {1'b0, thr[k]}) && ((k < 2) || spatial_en_q);
			masked[k] = acc[k] ? cand[k] : '0;
		end
		extremum = ((prev_frame_pixel < center_pixel) && (next_frame_pixel < center_pixel))
		        || ((prev_frame_pixel > center_pixel) && (next_frame_pixel > center_pixel));
	end

	pix_t              center_s1;
	logic              bypass_s1;
	logic [CAND_N-1:0] acc_s1;
	pix_t              masked_s1 [CAND_N];

	always_ff @(posedge clk) begin
		if (rdy1) begin
			center_s1 <= center_pixel;
			bypass_s1 <= is_border || !extremum;
			acc_s1    <= acc;
			masked_s1 <= masked;
		end
	end

	// stage 2: sum and count of accepted pixels
	logic [SUM_W-1:0] pair [CAND_N/2];
	logic [SUM_W-1:0] sum;
	logic [CNT_W-1:0] cnt;

	always_comb begin
		for (int k = 0; k < CAND_N/2; k++)
			pair[k] = SUM_W'(masked_s1[2*k]) + SUM_W'(masked_s1[2*k+1]);
		sum = ((pair[0] + pair[1]) + (pair[2] + pair[3])) + (pair[4] + SUM_W'(center_s1));
		cnt = CNT_W'(1) + CNT_W'($countones(acc_s1));
	end

	pix_t             center_s2;
	logic             bypass_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [CNT_W-1:0] cnt_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			center_s2 <= center_s1;
			bypass_s2 <= bypass_s1;
			sum_s2    <= sum;
			cnt_s2    <= cnt;
		end
	end

	// stage 3: rounded numerator times reciprocal
	logic [FACT_W-1:0] factor;
	assign factor = {sum_s2, 1'b0} + FACT_W'(cnt_s2);

	pix_t              center_s3;
	logic              bypass_s3;
	logic [PROD_W-1:0] prod_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			center_s3 <= center_s2;
			bypass_s3 <= bypass_s2;
			prod_s3   <= PROD_W'(factor) * PROD_W'(recip(cnt_s2));
		end
	end

	// stage 4: take high half, clamp, or pass the centre through
	logic [PROD_W-SHIFT-1:0] high;
	pix_t                    result;

	always_comb begin
		high   = prod_s3[PROD_W-1:SHIFT];
		if (bypass_s3)
			result = center_s3;
		else if (high > (PROD_W-SHIFT)'(PIX_MAX))
			result = PIX_MAX;
		else
			result = high[PIX_W-1:0];
	end

	pix_t pixel_s4;

	always_ff @(posedge clk) begin
		if (rdy4) pixel_s4 <= result;
	end

	assign out_valid = valid_s4;
	assign pixel_out = pixel_s4;

	// checks
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4))
		else $error("input stalled with a free pipeline slot");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cnt_s2 >= CNT_W'(1) && cnt_s2 <= CNT_W'(CAND_N + 1)))
		else $error("accepted count out of range");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (sum_s2 <= SUM_W'((CAND_N + 1) * 255)))
		else $error("sum exceeds eleven pixels");

	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && rdy4 && bypass_s3) |=> (out_valid && pixel_out == $past(center_s3)))
		else $error("pass-through pixel altered");

endmodule
`default_nettype wire

// ===== tb/sv/flux_smoother_checker.sv =====
// Checks the flux smoother: predicts each smoothed pixel and compares results in order.
`timescale 1ns / 1ps
module flux_smoother_checker
	import sfs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [PIX_W-1:0]     center_pixel,
	input  logic [PIX_W-1:0]     prev_frame_pixel,
	input  logic [PIX_W-1:0]     next_frame_pixel,
	input  logic [PIX_W-1:0]     up_left,
	input  logic [PIX_W-1:0]     up_mid,
	input  logic [PIX_W-1:0]     up_right,
	input  logic [PIX_W-1:0]     mid_left,
	input  logic [PIX_W-1:0]     mid_right,
	input  logic [PIX_W-1:0]     down_left,
	input  logic [PIX_W-1:0]     down_mid,
	input  logic [PIX_W-1:0]     down_right,
	input  logic                 is_border,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [PIX_W-1:0]     pixel_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   pending
);

	pix_t        temporal_thr;
	pix_t        spatial_thr;
	logic        spatial_on;
	logic [15:0] recip_lut [16];
	pix_t        expected_pixels [$];
	pix_t        want;

	function automatic logic near(pix_t cand, pix_t c, pix_t thr);
		pix_t diff;
		diff = (cand > c) ? cand - c : c - cand;
		return diff <= thr;
	endfunction

	function automatic pix_t smooth_pixel(pix_t c, pix_t p, pix_t n,
			logic [NBR_N-1:0][PIX_W-1:0] nbrs, logic border);
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
		logic [15:0]      factor;
		logic [31:0]      prod;
		logic [31:0]      avg;
		if (border || !((p < c && n < c) || (p > c && n > c)))
			return c;
		sum = SUM_W'(c);
		cnt = CNT_W'(1);
		if (near(p, c, temporal_thr)) begin
			sum += SUM_W'(p);
			cnt += CNT_W'(1);
		end
		if (near(n, c, temporal_thr)) begin
			sum += SUM_W'(n);
			cnt += CNT_W'(1);
		end
		if (spatial_on) begin
			for (int k = 0; k < NBR_N; k++) begin
				if (near(nbrs[k], c, spatial_thr)) begin
					sum += SUM_W'(nbrs[k]);
					cnt += CNT_W'(1);
				end
			end
		end
		factor = {3'b000, sum, 1'b0} + {12'd0, cnt};
		prod = {16'd0, factor} * {16'd0, recip_lut[cnt]};
		avg = prod >> SHIFT;
		return (avg > {24'd0, PIX_MAX}) ? PIX_MAX : avg[PIX_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temporal_thr = THR_RESET;
			spatial_thr = THR_RESET;
			spatial_on = 1'b1;
			recip_lut[0] = 16'd0;
			recip_lut[1] = 16'd32767;
			// round(32768 / i) for the rest
			for (int i = 2; i < 16; i++)
				recip_lut[i] = 16'((32768 + i / 2) / i);
			expected_pixels.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TEMPORAL_THR: temporal_thr = cfg_data;
					REG_SPATIAL_THR:  spatial_thr = cfg_data;
					REG_SPATIAL_EN:   spatial_on = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_pixels.push_back(smooth_pixel(center_pixel, prev_frame_pixel,
					next_frame_pixel, {down_right, down_mid, down_left, mid_right,
					mid_left, up_right, up_mid, up_left}, is_border));
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel_out: expected nothing, got %0d", pixel_out);
					mismatches++;
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_out !== want) begin
						$error("pixel_out: expected %0d, got %0d", want, pixel_out);
						mismatches++;
					end
				end
			end
			pending = expected_pixels.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the flux smoother testbench: clock, reset, request and config stimulus, verdict.
`timescale 1ns / 1ps
module testbench;
	import sfs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int LONG_HOLD     = 40;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 115;

	typedef struct packed {
		pix_t                        center;
		pix_t                        prev_f;
		pix_t                        next_f;
		logic [NBR_N-1:0][PIX_W-1:0] nbr;
		logic                        border;
	} nbhd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	pix_t center_pixel = '0;
	pix_t prev_frame_pixel = '0;
	pix_t next_frame_pixel = '0;
	pix_t up_left = '0, up_mid = '0, up_right = '0;
	pix_t mid_left = '0, mid_right = '0;
	pix_t down_left = '0, down_mid = '0, down_right = '0;
	logic is_border = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	pix_t pixel_out;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	int mismatches;
	int pending;
	bit send_idling = 1'b0;
	bit sink_idling = 1'b0;
	bit long_hold = 1'b0;

	spatiotemporal_flux_smoother dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.center_pixel(center_pixel), .prev_frame_pixel(prev_frame_pixel),
		.next_frame_pixel(next_frame_pixel),
		.up_left(up_left), .up_mid(up_mid), .up_right(up_right),
		.mid_left(mid_left), .mid_right(mid_right),
		.down_left(down_left), .down_mid(down_mid), .down_right(down_right),
		.is_border(is_border),
		.out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	flux_smoother_checker pixel_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.center_pixel(center_pixel), .prev_frame_pixel(prev_frame_pixel),
		.next_frame_pixel(next_frame_pixel),
		.up_left(up_left), .up_mid(up_mid), .up_right(up_right),
		.mid_left(mid_left), .mid_right(mid_right),
		.down_left(down_left), .down_mid(down_mid), .down_right(down_right),
		.is_border(is_border),
		.out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	always #1 clk = ~clk;

	initial begin
		#500000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: random stall bursts, plus one long hold-off on demand.
	always begin : result_sink
		int len;
		@(posedge clk);
		if (long_hold) begin
			out_stall <= 1'b1;
			repeat (LONG_HOLD) @(posedge clk);
			long_hold = 1'b0;
			out_stall <= 1'b0;
		end else if (sink_idling && $urandom_range(0, 4) == 0) begin
			len = $urandom_range(1, 4);
			out_stall <= 1'b1;
			repeat (len) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	function automatic pix_t clamp_pix(int v);
		if (v < 0)
			return '0;
		if (v > 255)
			return PIX_MAX;
		return v[PIX_W-1:0];
	endfunction

	function automatic pix_t offset(pix_t c, int lo, int hi);
		return clamp_pix(int'(c) + lo + int'($urandom_range(0, hi - lo)));
	endfunction

	function automatic pix_t rand_pix(int unsigned hi);
		return pix_t'($urandom_range(0, hi));
	endfunction

	function automatic nbhd_t flat_px(pix_t c, pix_t p, pix_t n, pix_t fill, logic border);
		nbhd_t px;
		px.center = c;
		px.prev_f = p;
		px.next_f = n;
		px.border = border;
		for (int k = 0; k < NBR_N; k++)
			px.nbr[k] = fill;
		return px;
	endfunction

	function automatic pix_t pick_thr();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return PIX_MAX;
			2: return rand_pix(15);
			default: return rand_pix(255);
		endcase
	endfunction

	function automatic nbhd_t random_px();
		nbhd_t px;
		int kind;
		int spread;
		kind = $urandom_range(0, 9);
		spread = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
		px.center = rand_pix(255);
		px.border = ($urandom_range(0, 9) == 0);
		for (int k = 0; k < NBR_N; k++)
			px.nbr[k] = (kind < 7) ? offset(px.center, -spread, spread) : rand_pix(255);
		if (kind < 7) begin
			// strict extremum with candidates close to the centre
			if ($urandom_range(0, 1)) begin
				px.prev_f = offset(px.center, 1, spread);
				px.next_f = offset(px.center, 1, spread);
			end else begin
				px.prev_f = offset(px.center, -spread, -1);
				px.next_f = offset(px.center, -spread, -1);
			end
		end else if (kind < 9) begin
			px.prev_f = rand_pix(255);
			px.next_f = rand_pix(255);
		end else begin
			// tie with one temporal pixel
			px.prev_f = px.center;
			px.next_f = rand_pix(255);
			if ($urandom_range(0, 1))
				{px.prev_f, px.next_f} = {px.next_f, px.prev_f};
		end
		return px;
	endfunction

	task automatic send_pixel(input nbhd_t px);
		int gap;
		if (send_idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		center_pixel <= px.center;
		prev_frame_pixel <= px.prev_f;
		next_frame_pixel <= px.next_f;
		up_left <= px.nbr[0];
		up_mid <= px.nbr[1];
		up_right <= px.nbr[2];
		mid_left <= px.nbr[3];
		mid_right <= px.nbr[4];
		down_left <= px.nbr[5];
		down_mid <= px.nbr[6];
		down_right <= px.nbr[7];
		is_border <= px.border;
		do @(posedge clk); while (in_stall);
	endtask

	// Hold the request side until every predicted pixel has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	task automatic apply_config(input pix_t t_thr, input pix_t s_thr,
			input logic [CFG_W-1:0] en_word);
		cfg_we <= 1'b1;
		cfg_index <= REG_TEMPORAL_THR;
		cfg_data <= t_thr;
		@(posedge clk);
		cfg_index <= REG_SPATIAL_THR;
		cfg_data <= s_thr;
		@(posedge clk);
		cfg_index <= REG_SPATIAL_EN;
		cfg_data <= en_word;
		@(posedge clk);
		// past the last register: must leave all three alone
		cfg_index <= REG_UNUSED;
		cfg_data <= rand_pix(255);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		nbhd_t px;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: thresholds 7, spatial on
		send_pixel(flat_px(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		send_pixel(flat_px(8'd200, 8'd198, 8'd199, 8'd200, 1'b1));
		send_pixel(flat_px(8'd100, 8'd100, 8'd50, 8'd100, 1'b0));
		send_pixel(flat_px(8'd100, 8'd50, 8'd100, 8'd100, 1'b0));
		send_pixel(flat_px(8'd255, 8'd250, 8'd252, 8'd255, 1'b0));
		send_pixel(flat_px(8'd0, 8'd3, 8'd5, 8'd0, 1'b0));
		send_pixel(flat_px(8'd128, 8'd255, 8'd255, 8'd0, 1'b0));
		send_pixel(flat_px(8'd255, 8'd0, 8'd0, 8'd0, 1'b0));
		px = flat_px(8'd100, 8'd93, 8'd92, 8'd107, 1'b0);
		px.nbr[1] = 8'd108;
		px.nbr[4] = 8'd93;
		px.nbr[6] = 8'd92;
		send_pixel(px);
		px = flat_px(8'd170, 8'd171, 8'd175, 8'h55, 1'b0);
		px.nbr[0] = 8'hAA;
		px.nbr[7] = 8'hAB;
		send_pixel(px);

		drain();
		apply_config(8'd0, 8'd0, 8'h01);
		send_pixel(flat_px(8'd60, 8'd61, 8'd200, 8'd60, 1'b0));
		send_pixel(flat_px(8'd255, 8'd0, 8'd254, 8'd255, 1'b0));

		drain();
		apply_config(PIX_MAX, PIX_MAX, 8'hFF);
		send_pixel(flat_px(8'd0, 8'd255, 8'd255, 8'd255, 1'b0));
		send_pixel(flat_px(8'd255, 8'd0, 8'd0, 8'd0, 1'b0));
		send_pixel(flat_px(8'd1, 8'd255, 8'd128, 8'd254, 1'b0));

		// enable word with only upper bits set turns spatial mode off
		drain();
		apply_config(8'd7, 8'd7, 8'hFE);
		send_pixel(flat_px(8'd50, 8'd45, 8'd44, 8'd50, 1'b0));
		send_pixel(flat_px(8'd50, 8'd57, 8'd60, 8'd51, 1'b0));

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			apply_config(pick_thr(), pick_thr(), rand_pix(255));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 40 == 0) begin
					send_idling = (ph < PHASES - 1) && $urandom_range(0, 2) != 0;
					sink_idling = (ph < PHASES - 1) && $urandom_range(0, 2) != 0;
				end
				// back the pipeline up while requests keep coming
				if (ph == 2 && i == 10) begin
					send_idling = 1'b0;
					long_hold = 1'b1;
				end
				send_pixel(random_px());
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
